// ----- rtl/core/bsp_pkg.sv -----
// ----------------------------------------------------------------------------
// bsp_pkg
// Shared constants, codes and types of the LSB-first bit stream packer.
// ----------------------------------------------------------------------------
package bsp_pkg;

  // Buffer geometry
  localparam int unsigned BUF_BYTES  = 4096;
  localparam int unsigned BUF_ADDR_W = $clog2(BUF_BYTES);
  localparam int unsigned LEN_W      = BUF_ADDR_W + 1;
  localparam int unsigned CUR_W      = 16;

  // Field widths
  localparam int unsigned FIELD_W    = 32;
  localparam int unsigned NBITS_W    = 6;
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned BYTE_W     = 8;

  localparam logic [NBITS_W-1:0] MAX_FIELD_BITS = NBITS_W'(32);
  localparam logic [NBITS_W-1:0] PREFIX_BITS    = NBITS_W'(16);
  localparam logic [FIELD_W-1:0] PREFIX_MAX     = FIELD_W'(32'h0000_FFFF);
  localparam logic [CUR_W-1:0]   CURSOR_LIMIT   = CUR_W'(BUF_BYTES * 8);

  // Stream widths
  localparam int unsigned IN_PACK_W   = FIELD_W + NBITS_W + BUF_ADDR_W + BYTE_W;
  localparam int unsigned IN_TDATA_W  = ((IN_PACK_W + 7) / 8) * 8;
  localparam int unsigned OUT_PACK_W  = FIELD_W + BYTE_W + 1 + CUR_W + LEN_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_PACK_W + 7) / 8) * 8;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_FIELD  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_STORE  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FETCH  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REWIND = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PREFIX = 3'd4;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_LEN  = 1'b1;

  typedef struct packed {
    logic [MODE_W-1:0]     mode;
    logic [FIELD_W-1:0]    field_value;
    logic [NBITS_W-1:0]    field_bits;
    logic [BUF_ADDR_W-1:0] address;
    logic [BYTE_W-1:0]     byte_data;
  } bsp_req_t;

  typedef struct packed {
    logic [FIELD_W-1:0] read_value;
    logic [BYTE_W-1:0]  byte_out;
    logic               error;
    logic [CUR_W-1:0]   bit_position;
    logic [LEN_W-1:0]   written_bytes;
  } bsp_result_t;

  typedef struct packed {
    logic             error;
    logic [CUR_W-1:0] cursor;
    logic [LEN_W-1:0] opened;
  } bsp_status_t;

endpackage

// ----- rtl/core/bsp_ram.sv -----
// ----------------------------------------------------------------------------
// bsp_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bsp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/bsp_engine.sv -----
// ----------------------------------------------------------------------------
// bsp_engine
// Byte-wise read-modify-write sequencer around the byte buffer memory.
// ----------------------------------------------------------------------------
module bsp_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  bsp_pkg::bsp_req_t             req_i,
  input  logic                          direction_i,
  input  logic [bsp_pkg::LEN_W-1:0]     eff_len_i,
  input  logic                          out_free_i,
  output logic                          ready_o,
  output logic                          done_o,
  output bsp_pkg::bsp_result_t          result_o,
  output bsp_pkg::bsp_status_t          status_o
);
  import bsp_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_BYTE = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [MODE_W-1:0]  mode_q, mode_d;
  logic [FIELD_W-1:0] val_q, val_d;
  logic [NBITS_W-1:0] rem_q, rem_d;
  logic [NBITS_W-1:0] pos_q, pos_d;
  logic [FIELD_W-1:0] acc_q, acc_d;
  logic [CUR_W-1:0]   cur_q, cur_d;
  logic               err_q, err_d;
  logic [LEN_W-1:0]   opened_q, opened_d;

  // memory port
  logic                  ram_we, ram_re;
  logic [BUF_ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [BYTE_W-1:0]     ram_wdata, ram_rdata;

  // per-byte datapath
  logic [LEN_W-1:0]   idx;
  logic [2:0]         off;
  logic [3:0]         room, take;
  logic [BYTE_W-1:0]  low_mask, byte_mask, base, wr_byte, rd_bits;
  logic               fresh, in_len, past_end;
  logic [CUR_W-1:0]   cur_next;
  logic [NBITS_W-1:0] rem_next, nb_sat;

  // length prefix check
  logic [CUR_W-1:0]   total, left;
  logic               prefix_err;

  bsp_ram #(
    .Width (BYTE_W),
    .Depth (BUF_BYTES)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign idx       = cur_q[CUR_W-1:3];
  assign off       = cur_q[2:0];
  assign past_end  = (cur_q >= CURSOR_LIMIT);
  assign room      = 4'd8 - {1'b0, off};
  assign take      = (rem_q < {2'b00, room}) ? rem_q[3:0] : room;
  assign low_mask  = BYTE_W'((9'd1 << take) - 9'd1);
  assign byte_mask = low_mask << off;
  assign fresh     = (idx >= opened_q);
  assign in_len    = (idx < eff_len_i);
  assign base      = fresh ? '0 : ram_rdata;
  assign wr_byte   = base | ((val_q[BYTE_W-1:0] << off) & byte_mask);
  assign rd_bits   = (ram_rdata >> off) & low_mask;
  assign cur_next  = cur_q + CUR_W'(take);
  assign rem_next  = rem_q - NBITS_W'(take);
  assign nb_sat    = (req_i.field_bits > MAX_FIELD_BITS) ? MAX_FIELD_BITS : req_i.field_bits;

  assign total      = {eff_len_i, 3'b000};
  assign left       = (total >= cur_q) ? (total - cur_q) : '0;
  assign prefix_err = (mode_q == MODE_PREFIX) && direction_i &&
                      (acc_q[15:0] > {3'b000, left[CUR_W-1:3]});

  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    val_d     = val_q;
    rem_d     = rem_q;
    pos_d     = pos_q;
    acc_d     = acc_q;
    cur_d     = cur_q;
    err_d     = err_q;
    opened_d  = opened_q;
    ram_we    = 1'b0;
    ram_waddr = idx[BUF_ADDR_W-1:0];
    ram_wdata = wr_byte;
    ram_re    = 1'b0;
    ram_raddr = cur_q[BUF_ADDR_W+2:3];
    done_o    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          mode_d  = req_i.mode;
          val_d   = req_i.field_value;
          rem_d   = '0;
          pos_d   = '0;
          acc_d   = '0;
          state_d = S_FIN;
          case (req_i.mode)
            MODE_FIELD: begin
              rem_d = nb_sat;
              if (nb_sat != '0) begin
                ram_re  = 1'b1;
                state_d = S_BYTE;
              end
            end
            MODE_PREFIX: begin
              val_d   = (req_i.field_value > PREFIX_MAX) ? PREFIX_MAX : req_i.field_value;
              rem_d   = PREFIX_BITS;
              ram_re  = 1'b1;
              state_d = S_BYTE;
            end
            MODE_STORE: begin
              ram_we    = 1'b1;
              ram_waddr = req_i.address;
              ram_wdata = req_i.byte_data;
            end
            MODE_FETCH: begin
              ram_re    = 1'b1;
              ram_raddr = req_i.address;
            end
            MODE_REWIND: begin
              cur_d = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_BYTE: begin
        if (past_end) begin
          // cursor parked at the buffer end: every remaining bit faults
          err_d   = 1'b1;
          rem_d   = '0;
          state_d = S_FIN;
        end else begin
          if (!direction_i) begin
            ram_we = 1'b1;
            if (fresh) begin
              opened_d = idx + LEN_W'(1);
            end
            val_d = val_q >> take;
          end else begin
            if (in_len) begin
              acc_d = acc_q | FIELD_W'({{(FIELD_W-BYTE_W){1'b0}}, rd_bits} << pos_q);
            end else begin
              err_d = 1'b1;
            end
            pos_d = pos_q + NBITS_W'(take);
          end
          cur_d = cur_next;
          rem_d = rem_next;
          if (rem_next == '0) begin
            state_d = S_FIN;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = cur_next[BUF_ADDR_W+2:3];
          end
        end
      end

      S_FIN: begin
        done_o = 1'b1;
        if (out_free_i) begin
          err_d   = err_q | prefix_err;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    result_o.read_value = '0;
    if (direction_i && (mode_q == MODE_FIELD)) begin
      result_o.read_value = acc_q;
    end else if (direction_i && (mode_q == MODE_PREFIX) && !prefix_err) begin
      result_o.read_value = acc_q;
    end
    result_o.byte_out      = (mode_q == MODE_FETCH) ? ram_rdata : '0;
    result_o.error         = err_q | prefix_err;
    result_o.bit_position  = cur_q;
    result_o.written_bytes = opened_q;
  end

  assign ready_o         = (state_q == S_IDLE);
  assign status_o.error  = err_q;
  assign status_o.cursor = cur_q;
  assign status_o.opened = opened_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cur_q    <= '0;
      err_q    <= 1'b0;
      opened_q <= '0;
    end else begin
      state_q  <= state_d;
      cur_q    <= cur_d;
      err_q    <= err_d;
      opened_q <= opened_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    val_q  <= val_d;
    rem_q  <= rem_d;
    pos_q  <= pos_d;
    acc_q  <= acc_d;
  end

endmodule

// ----- rtl/core/lsb_first_bit_stream_packer.sv -----
// Store, fetch, rewind and zero-width fields go straight to the result; a field or length
//   prefix first takes one read-modify-write per byte on the single buffer RAM (a cursor
//   at the end takes one step). Requests are taken one at a time: a new one only once the
//   previous one has finished.
// Reset: asynchronous active low; clears cursor, error flag, written-byte count and
//   config registers; buffer contents are undefined until written.
// ----------------------------------------------------------------------------
// lsb_first_bit_stream_packer
// Bit cursor over a byte buffer: packs or extracts LSB-first fields.
// ----------------------------------------------------------------------------
module lsb_first_bit_stream_packer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [bsp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [bsp_pkg::LEN_W-1:0]         cfg_data_i,
  // request stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: field_value[31:0], field_bits[37:32], address[49:38], byte_data[57:50]
  input  logic [bsp_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // tuser: mode[2:0]
  input  logic [bsp_pkg::MODE_W-1:0]        s_axis_tuser,
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata: read_value[31:0], byte_out[39:32], error[40], bit_position[56:41],
  //        written_bytes[69:57]
  output logic [bsp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import bsp_pkg::*;

  logic                   dir_q, dir_d;
  logic [LEN_W-1:0]       rlen_q, rlen_d;
  logic [LEN_W-1:0]       eff_len;

  logic                   s_acc;
  bsp_req_t               req;
  logic                   eng_ready, eng_done, out_free;
  bsp_result_t            result;
  bsp_status_t            status;

  logic                   m_valid_q, m_valid_d;
  logic [OUT_TDATA_W-1:0] m_data_q;

  // Config registers: to be written only while the engine is idle; the block itself does not enforce this.
  always_comb begin
    dir_d  = dir_q;
    rlen_d = rlen_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DIRECTION: dir_d  = cfg_data_i[0];
        CFG_READ_LEN:  rlen_d = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Read limit saturates at the buffer size.
  assign eff_len = (rlen_q > LEN_W'(BUF_BYTES)) ? LEN_W'(BUF_BYTES) : rlen_q;

  // Unpack the request: mode from tuser, the rest lowest field first in tdata.
  assign req.mode        = s_axis_tuser;
  assign req.field_value = s_axis_tdata[FIELD_W-1:0];
  assign req.field_bits  = s_axis_tdata[FIELD_W +: NBITS_W];
  assign req.address     = s_axis_tdata[FIELD_W+NBITS_W +: BUF_ADDR_W];
  assign req.byte_data   = s_axis_tdata[FIELD_W+NBITS_W+BUF_ADDR_W +: BYTE_W];

  assign s_axis_tready = eng_ready;
  assign s_acc         = s_axis_tvalid && eng_ready;

  // The output register frees up when empty or drained this cycle.
  assign out_free = !m_valid_q || m_axis_tready;

  bsp_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (s_acc),
    .req_i       (req),
    .direction_i (dir_q),
    .eff_len_i   (eff_len),
    .out_free_i  (out_free),
    .ready_o     (eng_ready),
    .done_o      (eng_done),
    .result_o    (result),
    .status_o    (status)
  );

  // Hold the result until taken; load a fresh one when the engine finishes.
  always_comb begin
    m_valid_d = m_valid_q;
    if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    if (eng_done && out_free) begin
      m_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q     <= 1'b0;
      rlen_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      dir_q     <= dir_d;
      rlen_q    <= rlen_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eng_done && out_free) begin
      m_data_q <= OUT_TDATA_W'({result.written_bytes, result.bit_position, result.error,
                                result.byte_out, result.read_value});
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

`ifndef SYNTH
  a_err_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.error |=> status.error)
    else $error("error flag dropped");

  a_opened_mono : assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (status.opened >= $past(status.opened)))
    else $error("written byte count decreased");

  a_cursor_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.cursor <= CURSOR_LIMIT)
    else $error("cursor beyond buffer end");

  a_one_at_a_time : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready)
    else $error("request accepted while engine busy");
`endif

endmodule

// ----- tb/tb_lsb_first_bit_stream_packer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lsb_first_bit_stream_packer
// Self-checking bench: drives requests on the slave stream, mirrors the
// packer's buffer, cursor and flags in a local predictor, and compares every
// result on the master stream field by field against the predicted one.
// ----------------------------------------------------------------------------
module tb_lsb_first_bit_stream_packer;
  import bsp_pkg::*;

  localparam int unsigned CURSOR_END    = BUF_BYTES * 8;
  localparam int unsigned SETTLE_CYCLES = 12;   // longest request latency plus margin
  localparam int unsigned HOLD_CYCLES   = 120;  // long receiver hold-off
  localparam int unsigned PRED_DEPTH    = 16;   // far above the requests in flight
  localparam logic [MODE_W-1:0] MODE_LAST = '1;  // codes above MODE_PREFIX are unused

  // --------------------------------------------------------------------------
  // Clock, reset and DUT ports; every input known from time zero
  // --------------------------------------------------------------------------
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [LEN_W-1:0]      cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // tdata: field_value[31:0], field_bits[37:32], address[49:38], byte_data[57:50]
  logic [IN_TDATA_W-1:0] s_axis_tdata  = '0;
  // tuser: mode[2:0]
  logic [MODE_W-1:0]     s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // tdata: read_value[31:0], byte_out[39:32], error[40], bit_position[56:41],
  //        written_bytes[69:57]
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  lsb_first_bit_stream_packer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // --------------------------------------------------------------------------
  // Predictor state: mirror of the buffer, the cursor and the config registers.
  // byte_known marks bytes whose content is defined (opened or stored).
  // --------------------------------------------------------------------------
  logic [BYTE_W-1:0] mirror_mem [BUF_BYTES];
  bit                byte_known [BUF_BYTES];
  int unsigned       cursor_bits  = 0;
  int unsigned       opened_cnt   = 0;
  bit                sticky_err   = 1'b0;
  bit                cfg_read_dir = 1'b0;
  logic [LEN_W-1:0]  cfg_read_len = '0;

  bsp_result_t  pred_fifo [PRED_DEPTH];  // predicted results, oldest at pred_rd
  int unsigned  pred_wr        = 0;
  int unsigned  pred_rd        = 0;
  int unsigned  mismatch_count = 0;
  bit           gaps_on        = 1'b1; // random idle cycles on both sides
  bit           hold_off       = 1'b0; // ask the receiver for one long hold-off

  // Readable length, capped at the buffer size
  function automatic int unsigned read_limit();
    return (cfg_read_len > BUF_BYTES) ? BUF_BYTES : int'(cfg_read_len);
  endfunction

  // Append bits LSB first; open (clear) each byte the first time it is touched
  function automatic void append_bits(logic [FIELD_W-1:0] value, int unsigned count);
    int unsigned idx;
    for (int unsigned i = 0; i < count; i++) begin
      idx = cursor_bits >> 3;
      if (idx >= BUF_BYTES) begin
        // past the end: drop the bit, park the cursor
        sticky_err = 1'b1;
        continue;
      end
      if (idx >= opened_cnt) begin
        mirror_mem[idx] = '0;
        byte_known[idx] = 1'b1;
        opened_cnt      = idx + 1;
      end
      if (value[i]) mirror_mem[idx][cursor_bits % 8] = 1'b1;
      cursor_bits++;
    end
  endfunction

  // Extract bits LSB first; bits past the readable length come back as zero
  function automatic logic [FIELD_W-1:0] extract_bits(int unsigned count);
    logic [FIELD_W-1:0] acc;
    int unsigned        idx;
    acc = '0;
    for (int unsigned i = 0; i < count; i++) begin
      idx = cursor_bits >> 3;
      if (idx < read_limit()) acc[i] = mirror_mem[idx][cursor_bits % 8];
      else sticky_err = 1'b1;
      if (cursor_bits < CURSOR_END) cursor_bits++;
    end
    return acc;
  endfunction

  // Advance the predictor by one accepted request and return its result
  function automatic bsp_result_t predict_request(bsp_req_t req);
    bsp_result_t        res;
    int unsigned        nbits;
    int unsigned        room;
    logic [FIELD_W-1:0] plen;
    res   = '0;
    nbits = (req.field_bits > MAX_FIELD_BITS) ? MAX_FIELD_BITS : req.field_bits;
    case (req.mode)
      MODE_FIELD: begin
        if (!cfg_read_dir) append_bits(req.field_value, nbits);
        else res.read_value = extract_bits(nbits);
      end
      // the 12-bit address always lies inside the buffer
      MODE_STORE: begin
        mirror_mem[req.address] = req.byte_data;
        byte_known[req.address] = 1'b1;
      end
      MODE_FETCH:  res.byte_out = mirror_mem[req.address];
      MODE_REWIND: cursor_bits = 0;
      MODE_PREFIX: begin
        if (!cfg_read_dir) begin
          append_bits((req.field_value > PREFIX_MAX) ? PREFIX_MAX : req.field_value,
                      PREFIX_BITS);
        end else begin
          plen = extract_bits(PREFIX_BITS);
          room = (read_limit() * 8 >= cursor_bits) ? read_limit() * 8 - cursor_bits : 0;
          if (plen > room / 8) sticky_err = 1'b1;
          else res.read_value = plen;
        end
      end
      default: ;
    endcase
    res.error         = sticky_err;
    res.bit_position  = CUR_W'(cursor_bits);
    res.written_bytes = LEN_W'(opened_cnt);
    return res;
  endfunction

  // First byte a request would read (or OR into) whose content is undefined
  function automatic int first_unknown_byte(bsp_req_t req);
    int unsigned nbits;
    int unsigned pos;
    int unsigned idx;
    if (req.mode == MODE_FETCH) return byte_known[req.address] ? -1 : int'(req.address);
    if (req.mode == MODE_PREFIX) nbits = PREFIX_BITS;
    else if (req.mode == MODE_FIELD)
      nbits = (req.field_bits > MAX_FIELD_BITS) ? MAX_FIELD_BITS : req.field_bits;
    else return -1;
    for (int unsigned i = 0; i < nbits; i++) begin
      pos = (cursor_bits + i > CURSOR_END) ? CURSOR_END : cursor_bits + i;
      idx = pos >> 3;
      if (!cfg_read_dir) begin
        if (idx < opened_cnt && !byte_known[idx]) return int'(idx);
      end else if (idx < read_limit() && !byte_known[idx]) begin
        return int'(idx);
      end
    end
    return -1;
  endfunction

  function automatic bsp_req_t req_of(logic [MODE_W-1:0] mode, logic [FIELD_W-1:0] value,
                                      int unsigned nbits, int unsigned addr,
                                      int unsigned data);
    bsp_req_t r;
    r.mode        = mode;
    r.field_value = value;
    r.field_bits  = NBITS_W'(nbits);
    r.address     = BUF_ADDR_W'(addr);
    r.byte_data   = BYTE_W'(data);
    return r;
  endfunction

  // Random content in every field, given mode and width
  function automatic bsp_req_t rand_req(logic [MODE_W-1:0] mode, int unsigned nbits);
    return req_of(mode, $urandom, nbits, $urandom_range(0, BUF_BYTES - 1),
                  $urandom_range(0, 255));
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: drive at the falling edge, take the handshake at the rising
  // edge. tvalid stays high into the next request when no gap is drawn.
  // --------------------------------------------------------------------------
  task automatic send_request(input bsp_req_t req);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 8) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req.mode;
    s_axis_tdata  <= IN_TDATA_W'({req.byte_data, req.address, req.field_bits,
                                  req.field_value});
    @(posedge clk_i);
    while (s_axis_tready !== 1'b1) @(posedge clk_i);
    pred_fifo[pred_wr % PRED_DEPTH] = predict_request(req);
    pred_wr++;
  endtask

  // Store random bytes wherever the request would touch undefined content,
  // then send the request itself
  task automatic issue(input bsp_req_t req);
    int hole;
    hole = first_unknown_byte(req);
    while (hole >= 0) begin
      send_request(req_of(MODE_STORE, $urandom, 0, hole, $urandom_range(0, 255)));
      hole = first_unknown_byte(req);
    end
    send_request(req);
  endtask

  // Drop tvalid and hold until every predicted result has come back
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (pred_wr == pred_rd);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Register write, only while the block is idle
  task automatic write_config(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= LEN_W'(value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == CFG_DIRECTION) cfg_read_dir = value[0];
    else cfg_read_len = LEN_W'(value);
  endtask

  function automatic int unsigned rand_width();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 63);
    return $urandom_range(1, 32);
  endfunction

  // --------------------------------------------------------------------------
  // Result sink: per result draw a stall, or honor a long hold-off request
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall;
    forever begin
      @(negedge clk_i);
      stall = gaps_on ? $urandom_range(0, 8) : 0;
      if (hold_off) begin
        stall    = stall + HOLD_CYCLES;
        hold_off = 1'b0;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (m_axis_tvalid !== 1'b1) @(posedge clk_i);
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin : result_check
    bsp_result_t want;
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      if (pred_wr == pred_rd) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
        mismatch_count++;
      end else begin
        want = pred_fifo[pred_rd % PRED_DEPTH];
        pred_rd++;
        check_field("read_value", want.read_value, m_axis_tdata[31:0]);
        check_field("byte_out", 32'(want.byte_out), 32'(m_axis_tdata[39:32]));
        check_field("error", 32'(want.error), 32'(m_axis_tdata[40]));
        check_field("bit_position", 32'(want.bit_position), 32'(m_axis_tdata[56:41]));
        check_field("written_bytes", 32'(want.written_bytes), 32'(m_axis_tdata[69:57]));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Write direction: widths zero, one, full, oversized; prefix saturation;
  // byte store/fetch at the top address and at 100; unused modes; OR after rewind
  task automatic test_directed_write();
    write_config(CFG_DIRECTION, 0);
    issue(req_of(MODE_PREFIX, 32'd2, 0, 0, 0));
    issue(req_of(MODE_FIELD, '1, 0, 0, 0));
    issue(req_of(MODE_FIELD, '1, 32, 0, 0));
    issue(req_of(MODE_FIELD, '0, 32, 0, 0));
    issue(req_of(MODE_FIELD, 32'd1, 1, 0, 0));
    issue(rand_req(MODE_FIELD, 63));
    issue(rand_req(MODE_FIELD, 7));
    issue(req_of(MODE_PREFIX, 32'h0001_2345, 0, 0, 0));
    issue(req_of(MODE_STORE, '0, 0, BUF_BYTES - 1, 255));
    issue(req_of(MODE_STORE, '1, 0, 100, 0));
    issue(req_of(MODE_FETCH, '0, 0, BUF_BYTES - 1, 0));
    issue(req_of(MODE_FETCH, '0, 0, 100, 0));
    for (int m = MODE_PREFIX + 1; m <= MODE_LAST; m++) issue(rand_req(MODE_W'(m), rand_width()));
    // rewound bytes are ORed into, not cleared; value bits above the width drop
    issue(rand_req(MODE_REWIND, 0));
    issue(req_of(MODE_FIELD, 32'hFFFF_FFE1, 5, 0, 0));
  endtask

  // Read back the same layout: valid prefix, widths, oversize prefix, overrun
  task automatic test_directed_read();
    write_config(CFG_READ_LEN, opened_cnt);
    write_config(CFG_DIRECTION, 1);
    issue(rand_req(MODE_REWIND, 0));
    issue(rand_req(MODE_PREFIX, 0));
    issue(rand_req(MODE_FIELD, 0));
    issue(rand_req(MODE_FIELD, 32));
    issue(rand_req(MODE_FIELD, 32));
    issue(rand_req(MODE_FIELD, 1));
    issue(rand_req(MODE_FIELD, 63));
    issue(rand_req(MODE_FIELD, 7));
    issue(rand_req(MODE_PREFIX, 0));  // reads the saturated prefix: too long
    issue(rand_req(MODE_FIELD, 32));  // past the readable length
  endtask

  // Phases alternate direction; read phases sweep the readable length.
  // Most traffic is framed (rewind, prefix, fields), the rest is noise.
  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned nfields;
    int unsigned limit;
    bsp_req_t    head;
    for (int phase = 0; phase < 10; phase++) begin
      write_config(CFG_DIRECTION, phase % 2);
      if (phase % 2) begin
        case ((phase / 2) % 5)
          0:       limit = opened_cnt;
          1:       limit = 0;
          2:       limit = BUF_BYTES;
          3:       limit = (1 << LEN_W) - 1;
          default: limit = $urandom_range(0, opened_cnt);
        endcase
        write_config(CFG_READ_LEN, limit);
      end
      sent = 0;
      while (sent < 8) begin
        if ($urandom_range(0, 99) < 70) begin
          if ($urandom_range(0, cfg_read_dir ? 3 : 9) == 0) issue(rand_req(MODE_REWIND, 0));
          head = rand_req(MODE_PREFIX, rand_width());
          if ($urandom_range(0, 3) != 0) head.field_value = $urandom_range(0, 12);
          issue(head);
          nfields = $urandom_range(1, 6);
          repeat (nfields) issue(rand_req(MODE_FIELD, $urandom_range(1, 32)));
          sent += nfields + 1;
        end else begin
          case ($urandom_range(0, 4))
            0: issue(rand_req(MODE_STORE, rand_width()));
            1: issue(rand_req(MODE_FETCH, rand_width()));
            2: issue(rand_req(MODE_W'($urandom_range(MODE_PREFIX + 1, MODE_LAST)),
                              rand_width()));
            3: issue(rand_req(MODE_FIELD, $urandom_range(0, 1) ? 0 : $urandom_range(33, 63)));
            default: issue(rand_req(MODE_FIELD, $urandom_range(0, 63)));
          endcase
          sent++;
        end
      end
    end
  endtask

  // Hold the result side off while requests keep coming back to back, so the
  // block backs up into its input; then pause until everything has drained
  task automatic test_back_pressure();
    gaps_on  = 1'b0;
    hold_off = 1'b1;
    repeat (40) issue(rand_req(MODE_FIELD, $urandom_range(1, 32)));
    wait_idle();
    gaps_on = 1'b1;
    repeat (15) issue(rand_req(MODE_FIELD, rand_width()));
  endtask

  // Write full fields until the cursor hits the end of the buffer, then keep
  // writing: the excess bits drop and the cursor stays parked
  task automatic test_fill_to_end();
    int unsigned n;
    write_config(CFG_DIRECTION, 0);
    issue(rand_req(MODE_REWIND, 0));
    n = 0;
    while (cursor_bits < CURSOR_END) begin
      gaps_on = (n < 400);  // leave a long stretch with no idling
      issue(rand_req(MODE_FIELD, 32));
      n++;
    end
    issue(rand_req(MODE_FIELD, 63));
    issue(rand_req(MODE_PREFIX, 0));
    issue(rand_req(MODE_FIELD, 0));
    issue(rand_req(MODE_FETCH, 0));
    gaps_on = 1'b1;
  endtask

  // Read direction at the saturated cursor, then over the full buffer with
  // the length at its extremes
  task automatic test_read_at_end();
    write_config(CFG_READ_LEN, BUF_BYTES);
    write_config(CFG_DIRECTION, 1);
    issue(rand_req(MODE_FIELD, 32));
    issue(rand_req(MODE_PREFIX, 0));
    issue(rand_req(MODE_FIELD, 63));
    issue(rand_req(MODE_REWIND, 0));
    issue(rand_req(MODE_PREFIX, 0));
    repeat (6) issue(rand_req(MODE_FIELD, rand_width()));
    write_config(CFG_READ_LEN, (1 << LEN_W) - 1);
    repeat (6) issue(rand_req(MODE_FIELD, rand_width()));
    write_config(CFG_READ_LEN, 0);
    issue(rand_req(MODE_REWIND, 0));
    issue(rand_req(MODE_FIELD, 8));
    issue(rand_req(MODE_PREFIX, 0));
  endtask

  // --------------------------------------------------------------------------
  // Sequence: reset once, run the tests, drain, report
  // --------------------------------------------------------------------------
  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed_write();
    test_directed_read();
    test_random_traffic();
    test_back_pressure();
    test_fill_to_end();
    test_read_at_end();
    wait_idle();
    if (mismatch_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // Hard stop: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/bsp_pkg.sv
rtl/core/bsp_ram.sv
rtl/core/bsp_engine.sv
rtl/core/lsb_first_bit_stream_packer.sv
tb/tb_lsb_first_bit_stream_packer.sv
